### sv/hmm_predictive_sampler_macros.svh
// Assertion macros for the HMM predictive sampler.
// Used by hmm_predictive_sampler.sv; no other dependencies.
`ifndef HMM_PREDICTIVE_SAMPLER_MACROS_SVH
`define HMM_PREDICTIVE_SAMPLER_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define HMM_ASSERT_IMPL(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define HMM_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);

`endif

### sv/hmm_pkg.sv
// Shared types and constants for the HMM predictive sampler.
// No dependencies.
`default_nettype none
package hmm_pkg;
  localparam logic [1:0] KIND_TRANS = 2'd0;
  localparam logic [1:0] KIND_EMIS  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;
  localparam logic [1:0] KIND_STEP  = 2'd3;
  localparam int CNT_BITS = 16;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_TRD   = 10'b0000000010,
    ST_TMAC  = 10'b0000000100,
    ST_NDIV  = 10'b0000001000,
    ST_COPY  = 10'b0000010000,
    ST_ERD   = 10'b0000100000,
    ST_EMAC  = 10'b0001000000,
    ST_SDIV  = 10'b0010000000,
    ST_DONE  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;
endpackage
`default_nettype wire

### sv/hmm_predictive_sampler.sv
// HMM one-step predictor: table loads and sequenced predict steps.
// Depends on hmm_pkg and hmm_predictive_sampler_macros.svh.
// Operation: a load is written on acceptance. A step runs the transition sums over N states,
//   normalises, runs the emission sums over M symbols and scans K symbols (K = 1..M), using
//   one shared multiplier and one restoring divider step.
// Throughput: one item at a time; in_tready is low while a step runs, and a finished step
//   holds in its last state while the previous result still waits.
// Reset: sync active-low; clears control, counters; 8 states, 16 symbols; tables unset.
`default_nettype none
`include "hmm_predictive_sampler_macros.svh"
module hmm_predictive_sampler #(
  parameter int MAX_STATES  = 8,
  parameter int MAX_SYMBOLS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // kind[1:0], row_index[4:2], col_index[8:5], prob_value[24:9], random_draw[40:25],
  // actual_symbol[44:41], zeros above
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // predicted_symbol[3:0], hit[4], hit_count[20:5], step_count[36:21], zeros above
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_wdata
);
  localparam int SW  = $clog2(MAX_STATES);
  localparam int OW  = $clog2(MAX_SYMBOLS);
  localparam int JD  = (MAX_STATES > MAX_SYMBOLS) ? MAX_STATES : MAX_SYMBOLS;
  localparam int JW  = $clog2(JD);
  localparam int TAW = $clog2(MAX_STATES * MAX_STATES);
  localparam int EAW = $clog2(MAX_STATES * MAX_SYMBOLS);
  localparam int SCW = $clog2(MAX_STATES + 1);
  localparam int OCW = $clog2(MAX_SYMBOLS + 1);
  localparam int AW  = FRAC_BITS + OW + SW + 1;  // accumulator / sum width
  localparam int KW  = $clog2(FRAC_BITS + 2);
  localparam logic [FRAC_BITS-1:0] FMAX = {FRAC_BITS{1'b1}};

  // field extraction
  logic [1:0]  f_kind;
  logic [2:0]  f_row;
  logic [3:0]  f_col;
  logic [15:0] f_val, f_draw;
  logic [3:0]  f_act;
  assign f_kind = in_tdata[1:0];
  assign f_row  = in_tdata[4:2];
  assign f_col  = in_tdata[8:5];
  assign f_val  = in_tdata[24:9];
  assign f_draw = in_tdata[40:25];
  assign f_act  = in_tdata[44:41];

  logic [FRAC_BITS-1:0] val_m, draw_m;
  always_comb begin
    val_m  = '0;
    draw_m = '0;
    for (int b = 0; b < FRAC_BITS && b < 16; b++) begin
      val_m[b]  = f_val[b];
      draw_m[b] = f_draw[b];
    end
  end

  // memories
  logic [FRAC_BITS-1:0] trans_mem [MAX_STATES*MAX_STATES];
  logic [FRAC_BITS-1:0] emis_mem  [MAX_STATES*MAX_SYMBOLS];
  logic [FRAC_BITS-1:0] dist_r    [MAX_STATES];
  logic [AW-1:0]        wsum_r    [JD];  // w[j] then e[o]
  logic [FRAC_BITS-1:0] trans_q, emis_q;

  logic [3:0] states_used_r;
  logic [4:0] symbols_used_r;
  logic [SCW-1:0] n_c;
  logic [OCW-1:0] m_c;
  always_comb begin
    if (states_used_r == 4'd0) n_c = SCW'(1);
    else if (32'(states_used_r) > MAX_STATES) n_c = SCW'(MAX_STATES);
    else n_c = SCW'(states_used_r);
    if (symbols_used_r == 5'd0) m_c = OCW'(1);
    else if (32'(symbols_used_r) > MAX_SYMBOLS) m_c = OCW'(MAX_SYMBOLS);
    else m_c = OCW'(symbols_used_r);
  end

  hmm_pkg::state_t st_r, st_nxt;
  logic [SW-1:0]  i_r;       // inner index (source state)
  logic [JW-1:0]  j_r;       // outer index (target state or symbol)
  logic [AW-1:0]  acc_r, total_r, cum_r;
  logic [AW-1:0]  rem_r;
  logic [FRAC_BITS:0] quo_r;
  logic [KW-1:0]  k_r;
  logic [FRAC_BITS-1:0] draw_r;
  logic [3:0]     act_r;
  logic [OW-1:0]  pred_r;
  logic           found_r;
  logic [hmm_pkg::CNT_BITS-1:0] hits_r, steps_r;
  logic           hit_c;
  logic           ovalid_r;
  logic [39:0]    odata_r;

  logic accept;
  logic out_free;
  assign in_tready = (st_r == hmm_pkg::ST_IDLE);
  assign accept = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

  // table writes and registered reads
  logic in_s_row, in_s_col, in_o_col;
  assign in_s_row = 32'(f_row) < MAX_STATES;
  assign in_s_col = 32'(f_col) < MAX_STATES;
  assign in_o_col = 32'(f_col) < MAX_SYMBOLS;
  always_ff @(posedge clk) begin
    if (accept && f_kind == hmm_pkg::KIND_TRANS && in_s_row && in_s_col)
      trans_mem[TAW'(32'(f_row) * MAX_STATES + 32'(f_col))] <= val_m;
    trans_q <= trans_mem[TAW'(32'(i_r) * MAX_STATES + 32'(j_r))];
  end
  always_ff @(posedge clk) begin
    if (accept && f_kind == hmm_pkg::KIND_EMIS && in_s_row && in_o_col)
      emis_mem[EAW'(32'(f_row) * MAX_SYMBOLS + 32'(f_col))] <= val_m;
    emis_q <= emis_mem[EAW'(32'(i_r) * MAX_SYMBOLS + 32'(j_r))];
  end

  // shared multiplier
  logic [2*FRAC_BITS-1:0] prod;
  logic [FRAC_BITS-1:0]   mul_b;
  assign mul_b = st_r == hmm_pkg::ST_TMAC ? trans_q : emis_q;
  assign prod  = dist_r[i_r] * mul_b;

  // shared restoring divider step
  logic [AW:0]   rem_sh;
  logic          ge;
  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, total_r};

  logic last_i, last_jn, last_jm, div_done;
  assign last_i  = 32'(i_r) == 32'(n_c) - 1;
  assign last_jn = 32'(j_r) == 32'(n_c) - 1;
  assign last_jm = 32'(j_r) == 32'(m_c) - 1;
  assign div_done = 32'(k_r) == FRAC_BITS;

  logic [AW-1:0] div_num;
  assign div_num = st_r == hmm_pkg::ST_NDIV ? wsum_r[j_r] : cum_r;

  logic [FRAC_BITS-1:0] next_dist [MAX_STATES];
  logic [FRAC_BITS:0]   qfin;
  logic                 pick;
  assign qfin = {quo_r[FRAC_BITS-1:0], ge};
  // draw falls within the cumulative share of the current symbol
  assign pick = total_r != '0 && {{(AW-FRAC_BITS){1'b0}}, draw_r} <= AW'(qfin);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hmm_pkg::ST_IDLE: if (accept && f_kind == hmm_pkg::KIND_STEP) st_nxt = hmm_pkg::ST_TRD;
      hmm_pkg::ST_TRD:  st_nxt = hmm_pkg::ST_TMAC;
      hmm_pkg::ST_TMAC: begin
        if (last_i && last_jn) st_nxt = hmm_pkg::ST_NDIV;
        else st_nxt = hmm_pkg::ST_TRD;
      end
      hmm_pkg::ST_NDIV: if (div_done && last_jn) st_nxt = hmm_pkg::ST_COPY;
      hmm_pkg::ST_COPY: st_nxt = hmm_pkg::ST_ERD;
      hmm_pkg::ST_ERD:  st_nxt = hmm_pkg::ST_EMAC;
      hmm_pkg::ST_EMAC: begin
        if (last_i && last_jm) st_nxt = hmm_pkg::ST_SDIV;
        else st_nxt = hmm_pkg::ST_ERD;
      end
      hmm_pkg::ST_SDIV: if (div_done && (last_jm || pick)) st_nxt = hmm_pkg::ST_DONE;
      hmm_pkg::ST_DONE: st_nxt = hmm_pkg::ST_OUT;
      hmm_pkg::ST_OUT:  if (out_free) st_nxt = hmm_pkg::ST_IDLE;
      default:          st_nxt = hmm_pkg::ST_IDLE;
    endcase
  end

  assign hit_c = 32'(pred_r) == 32'(act_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= hmm_pkg::ST_IDLE;
      states_used_r  <= 4'd8;
      symbols_used_r <= 5'd16;
      hits_r         <= '0;
      steps_r        <= '0;
      ovalid_r       <= 1'b0;
      i_r            <= '0;
      j_r            <= '0;
      k_r            <= '0;
      found_r        <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == 1'b0) states_used_r <= cfg_wdata[3:0];
        else symbols_used_r <= cfg_wdata;
      end
      // hold a finished step until the output register is free
      if (st_r == hmm_pkg::ST_OUT && out_free) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        hmm_pkg::ST_IDLE: begin
          if (accept && f_kind == hmm_pkg::KIND_INIT && in_s_row)
            dist_r[SW'(f_row)] <= val_m;
          if (accept && f_kind == hmm_pkg::KIND_STEP) begin
            i_r <= '0; j_r <= '0; acc_r <= '0; total_r <= '0;
            draw_r <= draw_m; act_r <= f_act;
          end
        end
        hmm_pkg::ST_TRD, hmm_pkg::ST_ERD: ;
        hmm_pkg::ST_TMAC, hmm_pkg::ST_EMAC: begin
          if (last_i) begin
            wsum_r[j_r] <= acc_r + AW'(prod >> FRAC_BITS);
            total_r <= total_r + acc_r + AW'(prod >> FRAC_BITS);
            acc_r <= '0;
            i_r <= '0;
            if ((st_r == hmm_pkg::ST_TMAC && last_jn) ||
                (st_r == hmm_pkg::ST_EMAC && last_jm)) begin
              j_r <= '0; k_r <= '0;
              if (st_r == hmm_pkg::ST_EMAC) begin
                cum_r <= (j_r == '0) ? acc_r + AW'(prod >> FRAC_BITS) : wsum_r[0];
                found_r <= 1'b0;
              end
            end else j_r <= j_r + 1'b1;
          end else begin
            acc_r <= acc_r + AW'(prod >> FRAC_BITS);
            i_r <= i_r + 1'b1;
          end
        end
        hmm_pkg::ST_NDIV, hmm_pkg::ST_SDIV: begin
          if (k_r == '0) begin
            // integer bit first, then FRAC_BITS fraction steps
            quo_r <= (FRAC_BITS+1)'(div_num >= total_r);
            rem_r <= div_num >= total_r ? div_num - total_r : div_num;
            k_r <= k_r + 1'b1;
          end else begin
            rem_r <= ge ? AW'(rem_sh - {1'b0, total_r}) : rem_r << 1;
            quo_r <= qfin;
            if (div_done) begin
              k_r <= '0;
              if (st_r == hmm_pkg::ST_NDIV) begin
                if (total_r == '0) next_dist[j_r[SW-1:0]] <= '0;
                else if (qfin > {1'b0, FMAX}) next_dist[j_r[SW-1:0]] <= FMAX;
                else next_dist[j_r[SW-1:0]] <= qfin[FRAC_BITS-1:0];
                if (!last_jn) j_r <= j_r + 1'b1;
                else j_r <= '0;
              end else begin
                if (pick) begin
                  found_r <= 1'b1; pred_r <= OW'(j_r);
                end else if (!last_jm) begin
                  j_r <= j_r + 1'b1;
                  cum_r <= cum_r + wsum_r[j_r + 1'b1];
                end
              end
            end else k_r <= k_r + 1'b1;
          end
        end
        hmm_pkg::ST_COPY: begin
          for (int s = 0; s < MAX_STATES; s++)
            if (s < 32'(n_c)) dist_r[s] <= next_dist[s];
          total_r <= '0; acc_r <= '0; i_r <= '0; j_r <= '0;
        end
        hmm_pkg::ST_DONE: begin
          if (!found_r) pred_r <= OW'(32'(m_c) - 1);
          if (steps_r != '1) steps_r <= steps_r + 1'b1;
        end
        hmm_pkg::ST_OUT: begin
          if (out_free) begin
            if (hit_c && hits_r != '1) hits_r <= hits_r + 1'b1;
            odata_r <= {3'd0, steps_r,
                        (hit_c && hits_r != '1) ? hits_r + 1'b1 : hits_r,
                        hit_c, 4'(32'(pred_r))};
          end
        end
        default: ;
      endcase
    end
  end

  `HMM_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, st_r == hmm_pkg::ST_IDLE, "ready outside idle")
  `HMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `HMM_ASSERT_NEXT(a_out_next, clk, rst_n, st_r == hmm_pkg::ST_OUT, out_tvalid, "no result after step")
  `HMM_ASSERT_IMPL(a_hits_le, clk, rst_n, 1'b1, hits_r <= steps_r, "hits exceed steps")
endmodule
`default_nettype wire
